@@ rtl/core/rvx_pkg.sv @@
package rvx_pkg;

    // Data memory geometry; the depth must be a power of two
    localparam int DMEM_WORDS = 1024;
    localparam int DMEM_AW    = $clog2(DMEM_WORDS);

    // Major opcodes of the executed subset
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;

    // funct3 / funct7 codes
    localparam logic [2:0] F3_ADDI = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_JALR = 3'd0;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BYTE = 3'd0;
    localparam logic [6:0] F7_BASE = 7'h00;

    // Outcome of one instruction as seen by the execute stage
    typedef struct packed {
        logic [31:0]        npc;
        logic               wr;       // register write, x0 already suppressed
        logic [4:0]         rd;
        logic [31:0]        val;
        logic               ld;       // load: value comes from data memory
        logic [DMEM_AW-1:0] ld_idx;
        logic               st;
        logic [31:0]        saddr;
        logic [31:0]        sdata;
        logic [3:0]         smask;
        logic [DMEM_AW-1:0] st_idx;
        logic               bad;
    } exe_res_t;

endpackage

@@ rtl/core/rvx_execute.sv @@
module rvx_execute
    import rvx_pkg::*;
(
    input  logic [31:0] ins,
    input  logic [31:0] pc,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output exe_res_t    res
);

    logic [6:0]  opcode;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] imm_u;
    logic [31:0] pc_plus4;
    logic [31:0] addr_i;
    logic [31:0] addr_s;
    logic        wr;
    logic        ld;
    logic        st;
    logic        bad;
    logic [31:0] val;
    logic [31:0] npc;
    logic [31:0] sdata;
    logic [3:0]  smask;

    // Field split and immediates
    assign opcode   = ins[6:0];
    assign rd       = ins[11:7];
    assign f3       = ins[14:12];
    assign f7       = ins[31:25];
    assign imm_i    = {{20{ins[31]}}, ins[31:20]};
    assign imm_s    = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    assign imm_b    = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j    = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    assign imm_u    = {ins[31:12], 12'b0};
    assign pc_plus4 = pc + 32'd4;
    assign addr_i   = op_a + imm_i;
    assign addr_s   = op_a + imm_s;

    // Decode and execute
    always_comb
    begin
        wr    = 1'b0;
        ld    = 1'b0;
        st    = 1'b0;
        bad   = 1'b0;
        val   = '0;
        npc   = pc_plus4;
        sdata = '0;
        smask = '0;
        case (opcode)
            OPC_OPIMM:
            begin
                if (f3 == F3_ADDI)
                begin
                    wr  = 1'b1;
                    val = addr_i;
                end
                else
                    bad = 1'b1;
            end
            OPC_LUI:
            begin
                wr  = 1'b1;
                val = imm_u;
            end
            OPC_AUIPC:
            begin
                wr  = 1'b1;
                val = pc + imm_u;
            end
            OPC_OP:
            begin
                if (f7 == F7_BASE && f3 == F3_XOR)
                begin
                    wr  = 1'b1;
                    val = op_a ^ op_b;
                end
                else if (f7 == F7_BASE && f3 == F3_SLTU)
                begin
                    wr  = 1'b1;
                    val = {31'b0, op_a < op_b};
                end
                else
                    bad = 1'b1;
            end
            OPC_JAL:
            begin
                wr  = 1'b1;
                val = pc_plus4;
                npc = pc + imm_j;
            end
            OPC_JALR:
            begin
                if (f3 == F3_JALR)
                begin
                    wr  = 1'b1;
                    val = pc_plus4;
                    npc = {addr_i[31:1], 1'b0};
                end
                else
                    bad = 1'b1;
            end
            OPC_BRANCH:
            begin
                if (f3 == F3_BEQ)
                begin
                    if (op_a == op_b)
                        npc = pc + imm_b;
                end
                else
                    bad = 1'b1;
            end
            OPC_LOAD:
            begin
                if (f3 == F3_WORD)
                    ld = 1'b1;
                else
                    bad = 1'b1;
            end
            OPC_STORE:
            begin
                if (f3 == F3_WORD)
                begin
                    st    = 1'b1;
                    sdata = op_b;
                    smask = 4'hF;
                end
                else if (f3 == F3_BYTE)
                begin
                    st    = 1'b1;
                    sdata = {4{op_b[7:0]}};
                    smask = 4'b0001 << addr_s[1:0];
                end
                else
                    bad = 1'b1;
            end
            default:
                bad = 1'b1;
        endcase
    end

    // Result record; writes to x0 are dropped; rd, val, saddr, sdata and smask read as zero when unused
    always_comb
    begin
        res        = '0;
        res.npc    = npc;
        res.wr     = wr && (rd != 5'd0);
        res.rd     = (wr && (rd != 5'd0)) ? rd : 5'd0;
        res.val    = (wr && (rd != 5'd0)) ? val : 32'd0;
        res.ld     = ld;
        res.ld_idx = addr_i[DMEM_AW+1:2];
        res.st     = st;
        res.saddr  = st ? addr_s : 32'd0;
        res.sdata  = sdata;
        res.smask  = smask;
        res.st_idx = addr_s[DMEM_AW+1:2];
        res.bad    = bad;
    end

endmodule

@@ rtl/core/rv32i_subset_execute_unit.sv @@
// Channel  | Direction | Payload
// s_axis   | in        | tdata[31:0] instruction
// m_axis   | out       | tdata[175:0] executed_pc .. unsupported, see port comment
//
// Most instructions go from execute straight to the output register, so one
// request per cycle can be accepted while the output drains and no load waits
// in the load stage. LW goes through that stage, which holds the data memory
// read, before its result and register write-back. After reset the data memory
// is swept to zero, one word a cycle, with s_axis_tready low until it ends.
// A full output register stalls execute; the decode stage then holds one request.
module rv32i_subset_execute_unit
    import rvx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] instruction
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [31:0] executed_pc, [63:32] next_pc, [64] reg_write, [69:65] dest_reg,
    // [101:70] dest_value, [102] store_write, [134:103] store_address,
    // [166:135] store_data, [170:167] store_mask, [171] unsupported,
    // [175:172] zero
    output logic [175:0] m_axis_tdata
);

    localparam int OUT_W = 176;

    // Memories
    logic [31:0] rf_mem   [32];
    logic [31:0] dmem_mem [DMEM_WORDS];

    logic [31:0]        rf_valid_reg;
    logic [31:0]        rf_a_reg;
    logic [31:0]        rf_b_reg;
    logic               ok_a_reg;
    logic               ok_b_reg;
    logic               fwd_a_vld_reg;
    logic               fwd_b_vld_reg;
    logic [31:0]        fwd_a_reg;
    logic [31:0]        fwd_b_reg;
    logic               vld_d_reg;
    logic [31:0]        ins_d_reg;
    logic [31:0]        pc_reg;
    logic               vld_m_reg;
    logic [31:0]        m_pc_reg;
    logic [31:0]        m_npc_reg;
    logic [4:0]         m_rd_reg;
    logic [31:0]        ld_data_reg;
    logic               out_vld_reg;
    logic [OUT_W-1:0]   out_data_reg;
    logic [OUT_W-1:0]   out_data_next;
    logic               clr_reg;
    logic [DMEM_AW-1:0] clr_cnt_reg;

    logic        accept;
    logic        out_free;
    logic        fire_e;
    logic        fire_m;
    logic [31:0] op_a;
    logic [31:0] op_b;
    exe_res_t    res;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic [4:0]  nxt_rs1;
    logic [4:0]  nxt_rs2;
    logic        hit_a;
    logic        hit_b;

    // Handshake and stage firing
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign fire_m        = vld_m_reg && out_free;
    assign fire_e        = vld_d_reg && !vld_m_reg && out_free;
    assign s_axis_tready = !clr_reg && (!vld_d_reg || fire_e);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

    // Operands: forwarded value, else stored value, else reset value zero
    assign op_a = fwd_a_vld_reg ? fwd_a_reg : (ok_a_reg ? rf_a_reg : 32'd0);
    assign op_b = fwd_b_vld_reg ? fwd_b_reg : (ok_b_reg ? rf_b_reg : 32'd0);

    rvx_execute u_exe (
        .ins  (ins_d_reg),
        .pc   (pc_reg),
        .op_a (op_a),
        .op_b (op_b),
        .res  (res)
    );

    // Register file write port, shared by execute and load write-back
    assign rf_we    = (fire_e && res.wr) || (fire_m && (m_rd_reg != 5'd0));
    assign rf_waddr = fire_m ? m_rd_reg : res.rd;
    assign rf_wdata = fire_m ? ld_data_reg : res.val;

    // Forward a write that lands after the operand read of the request in decode
    assign nxt_rs1 = accept ? s_axis_tdata[19:15] : ins_d_reg[19:15];
    assign nxt_rs2 = accept ? s_axis_tdata[24:20] : ins_d_reg[24:20];
    assign hit_a   = rf_we && (rf_waddr == nxt_rs1);
    assign hit_b   = rf_we && (rf_waddr == nxt_rs2);

    // Register file array: read on accept, write on retire
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rf_a_reg <= rf_mem[s_axis_tdata[19:15]];
            rf_b_reg <= rf_mem[s_axis_tdata[24:20]];
        end
        if (rf_we)
            rf_mem[rf_waddr] <= rf_wdata;
    end

    // Register file valid bits and forwarding state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg  <= '0;
            ok_a_reg      <= 1'b0;
            ok_b_reg      <= 1'b0;
            fwd_a_vld_reg <= 1'b0;
            fwd_b_vld_reg <= 1'b0;
        end
        else
        begin
            if (rf_we)
                rf_valid_reg[rf_waddr] <= 1'b1;
            if (accept)
            begin
                ok_a_reg <= rf_valid_reg[s_axis_tdata[19:15]];
                ok_b_reg <= rf_valid_reg[s_axis_tdata[24:20]];
            end
            if (accept || hit_a)
                fwd_a_vld_reg <= hit_a;
            if (accept || hit_b)
                fwd_b_vld_reg <= hit_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit_a)
            fwd_a_reg <= rf_wdata;
        if (hit_b)
            fwd_b_reg <= rf_wdata;
    end

    // Data memory: clearing sweep, byte-lane stores, load reads
    always_ff @(posedge clk)
    begin
        if (clr_reg)
            dmem_mem[clr_cnt_reg] <= '0;
        else if (fire_e && res.st)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (res.smask[i])
                    dmem_mem[res.st_idx][i*8 +: 8] <= res.sdata[i*8 +: 8];
            end
        end
        if (fire_e && res.ld)
            ld_data_reg <= dmem_mem[res.ld_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + DMEM_AW'(1);
            if (clr_cnt_reg == DMEM_AW'(DMEM_WORDS - 1))
                clr_reg <= 1'b0;
        end
    end

    // Decode stage, PC and load stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            vld_m_reg <= 1'b0;
            pc_reg    <= '0;
        end
        else
        begin
            if (accept)
                vld_d_reg <= 1'b1;
            else if (fire_e)
                vld_d_reg <= 1'b0;
            if (fire_e)
                pc_reg <= res.npc;
            if (fire_e && res.ld)
                vld_m_reg <= 1'b1;
            else if (fire_m)
                vld_m_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ins_d_reg <= s_axis_tdata;
        if (fire_e && res.ld)
        begin
            m_pc_reg  <= pc_reg;
            m_npc_reg <= res.npc;
            m_rd_reg  <= ins_d_reg[11:7];
        end
    end

    // Result packing
    always_comb
    begin
        if (fire_m)
            out_data_next = {4'b0, 1'b0, 4'b0, 32'd0, 32'd0, 1'b0,
                             (m_rd_reg != 5'd0) ? ld_data_reg : 32'd0,
                             m_rd_reg, (m_rd_reg != 5'd0), m_npc_reg, m_pc_reg};
        else
            out_data_next = {4'b0, res.bad,
                             res.st ? res.smask : 4'd0,
                             res.st ? res.sdata : 32'd0,
                             res.saddr, res.st,
                             res.val, res.rd, res.wr, res.npc, pc_reg};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if ((fire_e && !res.ld) || fire_m)
            out_vld_reg <= 1'b1;
        else if (m_axis_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((fire_e && !res.ld) || fire_m)
            out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    // No request is taken while the data memory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !s_axis_tready)
        else $error("request accepted during data memory clear");

    // Execute and load write-back never retire in the same cycle
    a_single_retire: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire_e && fire_m))
        else $error("execute and load write-back retired together");

    // A load that leaves execute is held in the load stage next cycle
    a_load_to_m: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_e && res.ld) |=> vld_m_reg)
        else $error("load lost between execute and write-back");

    // x0 never gets a stored value
    a_x0_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("x0 was written");

    // A result waiting on a stalled output is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !m_axis_tready) |=> $stable(out_data_reg))
        else $error("pending result overwritten");
`endif

endmodule
